@@ rtl/vdlc_pkg.sv @@
// ----------------------------------------------------------------------------
// vdlc_pkg
// Types and codes shared by the viewer distance LOD classifier.
// ----------------------------------------------------------------------------
package vdlc_pkg;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [31:0] CNT_MAX  = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REG_FULL_RADIUS      = 3'd0,
    REG_SIMP_RADIUS      = 3'd1,
    REG_FULL_INTERVAL    = 3'd2,
    REG_SIMP_INTERVAL    = 3'd3,
    REG_SLEEP_INTERVAL   = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_START    = 2'd0,
    MODE_ADD      = 2'd1,
    MODE_CLASSIFY = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_RADIUS    = 3'd1,
    ST_BAD_INTERVAL  = 3'd2,
    ST_MISSING_SAVE  = 3'd3,
    ST_UNEXP_SAVE    = 3'd4,
    ST_NEG_TIME      = 3'd5,
    ST_MISSING_PROC  = 3'd6,
    ST_TIME_REVERSED = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    LVL_FULL       = 2'd0,
    LVL_SIMPLIFIED = 2'd1,
    LVL_SLEEPING   = 2'd2,
    LVL_UNLOADED   = 2'd3
  } level_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [63:0] coord_x;
    logic signed [63:0] coord_y;
    logic signed [63:0] coord_z;
    logic               persistent;
    logic               has_save_id;
    logic               is_process_owner;
    logic               has_process_id;
    logic               asleep;
    logic [2:0]         forced_level;
    logic signed [63:0] last_update_ms;
    logic signed [63:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  level;
    logic [63:0] nearest_sq;
    logic [62:0] elapsed_ms;
    logic [62:0] offline_ms;
    logic        due;
    logic [31:0] full_total;
    logic [31:0] simplified_total;
    logic [31:0] sleeping_total;
    logic [31:0] unloaded_total;
    logic [31:0] due_total;
  } out_t;

  typedef struct packed {
    logic [31:0]        full_dist;
    logic [31:0]        simp_dist;
    logic signed [31:0] full_interval_ms;
    logic signed [31:0] simplified_interval_ms;
    logic signed [31:0] sleeping_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] z;
    logic        asleep;
    logic [2:0]  forced;
    logic [2:0]  status;
    logic [62:0] elapsed;
  } cmd_t;

endpackage

@@ rtl/vdlc_fifo.sv @@
// ----------------------------------------------------------------------------
// vdlc_fifo
// Small synchronous queue with full/empty flags.
// ----------------------------------------------------------------------------
module vdlc_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T              mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/vdlc_front.sv @@
// ----------------------------------------------------------------------------
// vdlc_front
// Holds the policy registers and checks each incoming item.
// ----------------------------------------------------------------------------
module vdlc_front import vdlc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  in_t         item_i,
  output cmd_t        cmd_o,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic [2:0] status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_dist              <= 32'd64;
      cfg_q.simp_dist              <= 32'd256;
      cfg_q.full_interval_ms       <= 32'sd50;
      cfg_q.simplified_interval_ms <= 32'sd250;
      cfg_q.sleeping_interval_ms   <= 32'sd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FULL_RADIUS:    cfg_q.full_dist              <= cfg_data_i;
        REG_SIMP_RADIUS:    cfg_q.simp_dist              <= cfg_data_i;
        REG_FULL_INTERVAL:  cfg_q.full_interval_ms       <= cfg_data_i;
        REG_SIMP_INTERVAL:  cfg_q.simplified_interval_ms <= cfg_data_i;
        REG_SLEEP_INTERVAL: cfg_q.sleeping_interval_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (cfg_q.full_dist > cfg_q.simp_dist) begin
      status = ST_BAD_RADIUS;
    end else if (cfg_q.full_interval_ms <= 0 || cfg_q.simplified_interval_ms <= 0 ||
                 cfg_q.sleeping_interval_ms <= 0) begin
      status = ST_BAD_INTERVAL;
    end else if (item_i.persistent && !item_i.has_save_id) begin
      status = ST_MISSING_SAVE;
    end else if (!item_i.persistent && item_i.has_save_id) begin
      status = ST_UNEXP_SAVE;
    end else if (item_i.last_update_ms[63]) begin
      status = ST_NEG_TIME;
    end else if (item_i.is_process_owner && !item_i.has_process_id) begin
      status = ST_MISSING_PROC;
    end else if (item_i.now_ms < item_i.last_update_ms) begin
      status = ST_TIME_REVERSED;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    cmd_o.mode    = item_i.mode;
    cmd_o.x       = item_i.coord_x;
    cmd_o.y       = item_i.coord_y;
    cmd_o.z       = item_i.coord_z;
    cmd_o.asleep  = item_i.asleep;
    cmd_o.forced  = item_i.forced_level;
    cmd_o.status  = status;
    cmd_o.elapsed = 63'(item_i.now_ms - item_i.last_update_ms);
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/vdlc_engine.sv @@
// ----------------------------------------------------------------------------
// vdlc_engine
// Viewer table, nearest-viewer walk, level pick and frame counters.
// ----------------------------------------------------------------------------
module vdlc_engine import vdlc_pkg::*; #(
  parameter int unsigned MaxViewers = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  output out_t res_o,
  output logic res_push_o,
  input  logic res_full_i
);

  localparam int unsigned FillW = $clog2(MaxViewers + 1);
  localparam int unsigned IdxW  = (MaxViewers > 1) ? $clog2(MaxViewers) : 1;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DRAIN, S_FIN} state_e;

  function automatic logic [63:0] axis_diff(logic [63:0] a, logic [63:0] b);
    logic [63:0] l, r;
    l = a ^ SIGN_BIT;
    r = b ^ SIGN_BIT;
    return (l >= r) ? l - r : r - l;
  endfunction

  function automatic logic [63:0] sat_sq(logic [63:0] v);
    return (v[63:32] != '0) ? '1 : 64'(v[31:0]) * 64'(v[31:0]);
  endfunction

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == CNT_MAX) ? c : c + 32'd1;
  endfunction

  state_e          state_q;
  cmd_t            cur_q;
  logic [191:0]    mem_q [MaxViewers];
  logic [191:0]    rd_q;
  logic [FillW-1:0] fill_q;
  logic [IdxW-1:0] idx_q;
  logic [3:0]      v_q;
  logic [63:0]     d_q [3];
  logic [63:0]     sq_q [3];
  logic [63:0]     s12_q, sqz_q, near_q, tot;
  logic [63:0]     fsq_q, ssq_q;
  logic [31:0]     cnt_q [4];
  logic [31:0]     due_q;
  logic            issue, last_issue;
  logic [1:0]      level;
  logic            due;
  logic signed [31:0] iv;
  logic            ok;

  assign ok         = (cur_q.status == ST_OK);
  assign cmd_pop_o  = (state_q == S_IDLE) && !cmd_empty_i;
  assign issue      = (state_q == S_WALK);
  assign last_issue = (FillW'(idx_q) + FillW'(1) == fill_q);
  assign tot        = sat_add(s12_q, sqz_q);

  always_comb begin
    if (cur_q.forced <= 3'd3) begin
      level = cur_q.forced[1:0];
    end else begin
      priority if (near_q <= fsq_q) level = LVL_FULL;
      else if (near_q <= ssq_q)     level = LVL_SIMPLIFIED;
      else                          level = LVL_UNLOADED;
      if (cur_q.asleep && level != LVL_UNLOADED) level = LVL_SLEEPING;
    end
    unique case (level)
      LVL_FULL:       iv = cfg_i.full_interval_ms;
      LVL_SIMPLIFIED: iv = cfg_i.simplified_interval_ms;
      default:        iv = cfg_i.sleeping_interval_ms;
    endcase
    due = (level != LVL_UNLOADED) && ({1'b0, cur_q.elapsed} >= {32'd0, iv});
  end

  always_comb begin
    res_push_o = (state_q == S_FIN) && !res_full_i;
    res_o      = '0;
    res_o.status           = cur_q.status;
    res_o.full_total       = cnt_q[0];
    res_o.simplified_total = cnt_q[1];
    res_o.sleeping_total   = cnt_q[2];
    res_o.unloaded_total   = cnt_q[3];
    res_o.due_total        = due_q;
    if (ok) begin
      res_o.level      = level;
      res_o.nearest_sq = near_q;
      res_o.elapsed_ms = cur_q.elapsed;
      res_o.offline_ms = (level == LVL_UNLOADED) ? cur_q.elapsed : '0;
      res_o.due        = due;
      unique case (level)
        LVL_FULL:       res_o.full_total       = bump(cnt_q[0]);
        LVL_SIMPLIFIED: res_o.simplified_total = bump(cnt_q[1]);
        LVL_SLEEPING:   res_o.sleeping_total   = bump(cnt_q[2]);
        default:        res_o.unloaded_total   = bump(cnt_q[3]);
      endcase
      if (due) res_o.due_total = bump(due_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o && cmd_i.mode == MODE_ADD && fill_q < FillW'(MaxViewers)) begin
      mem_q[fill_q[IdxW-1:0]] <= {cmd_i.x, cmd_i.y, cmd_i.z};
    end
    rd_q     <= mem_q[idx_q];
    d_q[0]   <= axis_diff(cur_q.x, rd_q[191:128]);
    d_q[1]   <= axis_diff(cur_q.y, rd_q[127:64]);
    d_q[2]   <= axis_diff(cur_q.z, rd_q[63:0]);
    sq_q[0]  <= sat_sq(d_q[0]);
    sq_q[1]  <= sat_sq(d_q[1]);
    sq_q[2]  <= sat_sq(d_q[2]);
    s12_q    <= sat_add(sq_q[0], sq_q[1]);
    sqz_q    <= sq_q[2];
    fsq_q    <= 64'(cfg_i.full_dist) * 64'(cfg_i.full_dist);
    ssq_q    <= 64'(cfg_i.simp_dist) * 64'(cfg_i.simp_dist);
    if (cmd_pop_o) cur_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
      idx_q   <= '0;
      v_q     <= '0;
      near_q  <= '1;
      due_q   <= '0;
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
    end else begin
      v_q <= {v_q[2:0], issue};
      if (v_q[3] && tot < near_q) near_q <= tot;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_pop_o) begin
            idx_q  <= '0;
            near_q <= '1;
            case (cmd_i.mode)
              MODE_START: begin
                fill_q <= '0;
                due_q  <= '0;
                for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
              end
              MODE_ADD: begin
                if (fill_q < FillW'(MaxViewers)) fill_q <= fill_q + FillW'(1);
              end
              MODE_CLASSIFY: begin
                if (cmd_i.status != ST_OK) state_q <= S_FIN;
                else if (fill_q == '0)    state_q <= S_DRAIN;
                else                      state_q <= S_WALK;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (last_issue) state_q <= S_DRAIN;
          else            idx_q   <= idx_q + IdxW'(1);
        end
        S_DRAIN: begin
          if (v_q == '0) state_q <= S_FIN;
        end
        S_FIN: begin
          if (res_push_o) begin
            state_q  <= S_IDLE;
            cnt_q[0] <= res_o.full_total;
            cnt_q[1] <= res_o.simplified_total;
            cnt_q[2] <= res_o.sleeping_total;
            cnt_q[3] <= res_o.unloaded_total;
            due_q    <= res_o.due_total;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i) else $error("result push into full queue");
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MaxViewers)) else $error("viewer fill overflow");
  a_walk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK || state_q == S_DRAIN) |-> ok) else $error("walk on error item");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (state_q != S_WALK) || (fill_q != '0))
    else $error("walk with empty viewer table");

endmodule

@@ rtl/viewer_distance_lod_classifier.sv @@
// ----------------------------------------------------------------------------
// viewer_distance_lod_classifier
// Viewer table and per-subject level-of-detail classification.
//
//   channel  handshake           payload
//   input    push / full         in_item_i  (in_t)
//   result   pop / empty         out_item_o (out_t)
//   config   cfg_we_i, cfg_idx_i cfg_data_i (32 bit)
//
// Start-frame and add-viewer beats are handled as they are popped in the engine.
// A classify beat is popped, reads each stored viewer in turn, waits while the
// distance pipe drains and then pushes its result; an empty table has no walk.
// An error beat skips the walk and the drain and goes straight to the push.
// Two-entry queues sit on the command and result sides; either side may stall.
// Reset is asynchronous; it clears control state and sets policy registers to defaults.
// ----------------------------------------------------------------------------
module viewer_distance_lod_classifier import vdlc_pkg::*; #(
  parameter int unsigned MaxViewers = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_t         in_item_i,
  input  logic        pop,
  output logic        empty,
  output out_t        out_item_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd_in, cmd_out;
  cfg_t cfg;
  logic cmd_empty, cmd_pop;
  out_t res;
  logic res_push, res_full;

  vdlc_front u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_i(in_item_i), .cmd_o(cmd_in), .cfg_o(cfg)
  );

  vdlc_fifo #(.T(cmd_t), .Depth(2)) u_cmdq (
    .clk_i, .rst_ni, .push_i(push), .data_i(cmd_in), .full_o(full),
    .pop_i(cmd_pop), .data_o(cmd_out), .empty_o(cmd_empty)
  );

  vdlc_engine #(.MaxViewers(MaxViewers)) u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg), .cmd_i(cmd_out), .cmd_empty_i(cmd_empty),
    .cmd_pop_o(cmd_pop), .res_o(res), .res_push_o(res_push), .res_full_i(res_full)
  );

  vdlc_fifo #(.T(out_t), .Depth(2)) u_resq (
    .clk_i, .rst_ni, .push_i(res_push), .data_i(res), .full_o(res_full),
    .pop_i(pop), .data_o(out_item_o), .empty_o(empty)
  );

endmodule
